@@ rtl/core/ptlq_pkg.sv @@
`default_nettype none

package ptlq_pkg;

  localparam int unsigned NormalDepthDef   = 16;
  localparam int unsigned PriorityDepthDef = 16;
  localparam int unsigned LogDepthDef      = 16;

  localparam int unsigned IdW     = 16;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ActW    = 2;

  typedef enum logic [ReqW-1:0] {
    ReqAddNormal   = 2'd0,
    ReqAddPriority = 2'd1,
    ReqProcess     = 2'd2,
    ReqUndo        = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StsAdded      = 3'd0,
    StsServedPrio = 3'd1,
    StsServedNorm = 3'd2,
    StsNothing    = 3'd3,
    StsUndo       = 3'd4,
    StsUndoEmpty  = 3'd5,
    StsFull       = 3'd6
  } status_e;

  typedef enum logic [ActW-1:0] {
    ActAddNormal   = 2'd0,
    ActAddPriority = 2'd1,
    ActProcess     = 2'd2
  } act_e;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/ptlq_ram.sv @@
`default_nettype none

module ptlq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/ptlq_ctrl.sv @@
`default_nettype none

module ptlq_ctrl
  import ptlq_pkg::*;
#(
  parameter int unsigned NormalDepth   = NormalDepthDef,
  parameter int unsigned PriorityDepth = PriorityDepthDef,
  parameter int unsigned LogDepth      = LogDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [ReqW-1:0]                  s_req_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  output logic      [StatusW-1:0]               m_status_o,
  output logic      [IdW-1:0]                   m_served_o,
  output logic      [ActW-1:0]                  m_undone_o,
  output logic                                  n_we_o,
  output logic      [$clog2(NormalDepth)-1:0]   n_waddr_o,
  output logic                                  n_re_o,
  output logic      [$clog2(NormalDepth)-1:0]   n_raddr_o,
  input  wire logic [IdW-1:0]                   n_rdata_i,
  output logic                                  p_we_o,
  output logic      [$clog2(PriorityDepth)-1:0] p_waddr_o,
  output logic                                  p_re_o,
  output logic      [$clog2(PriorityDepth)-1:0] p_raddr_o,
  input  wire logic [IdW-1:0]                   p_rdata_i,
  output logic                                  l_we_o,
  output logic      [$clog2(LogDepth)-1:0]      l_waddr_o,
  output logic      [ActW-1:0]                  l_wdata_o,
  output logic                                  l_re_o,
  output logic      [$clog2(LogDepth)-1:0]      l_raddr_o,
  input  wire logic [ActW-1:0]                  l_rdata_i
);

  localparam int unsigned NIW = $clog2(NormalDepth);
  localparam int unsigned NCW = $clog2(NormalDepth + 1);
  localparam int unsigned PIW = $clog2(PriorityDepth);
  localparam int unsigned PCW = $clog2(PriorityDepth + 1);
  localparam int unsigned LIW = $clog2(LogDepth);
  localparam int unsigned LCW = $clog2(LogDepth + 1);

  localparam logic [NCW-1:0] NFull = NCW'(NormalDepth);
  localparam logic [PCW-1:0] PFull = PCW'(PriorityDepth);
  localparam logic [LCW-1:0] LFull = LCW'(LogDepth);
  localparam logic [NIW-1:0] NLast = NIW'(NormalDepth - 1);
  localparam logic [LIW-1:0] LLast = LIW'(LogDepth - 1);

  state_e         state_q, state_d;
  status_e        sts_q, sts_d;
  logic [NIW-1:0] nhead_q, nhead_d, ntail_q, ntail_d;
  logic [NCW-1:0] ncount_q, ncount_d;
  logic [PCW-1:0] pcount_q, pcount_d;
  logic [LIW-1:0] ltop_q, ltop_d;
  logic [LCW-1:0] lcount_q, lcount_d;

  logic               mvalid_q, mvalid_d;
  logic [StatusW-1:0] mstatus_q, mstatus_d;
  logic [IdW-1:0]     mserved_q, mserved_d;
  logic [ActW-1:0]    mundone_q, mundone_d;

  logic accept, load, log_rec;
  req_e req;

  assign req    = req_e'(s_req_i);
  assign accept = s_tvalid_i && s_tready_o;
  assign load   = (state_q == StExec) && (!mvalid_q || m_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (s_tvalid_i) state_d = StExec;
      StExec:  if (!mvalid_q || m_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_tready_o = (state_q == StIdle);
  end

  always_comb begin
    sts_d     = sts_q;
    nhead_d   = nhead_q;
    ntail_d   = ntail_q;
    ncount_d  = ncount_q;
    pcount_d  = pcount_q;
    ltop_d    = ltop_q;
    lcount_d  = lcount_q;
    log_rec   = 1'b0;
    n_we_o    = 1'b0;
    n_waddr_o = ntail_q;
    n_re_o    = 1'b0;
    n_raddr_o = nhead_q;
    p_we_o    = 1'b0;
    p_waddr_o = PIW'(pcount_q);
    p_re_o    = 1'b0;
    p_raddr_o = PIW'(pcount_q - 1'b1);
    l_we_o    = 1'b0;
    l_waddr_o = ltop_q;
    l_wdata_o = ActAddNormal;
    l_re_o    = 1'b0;
    l_raddr_o = (ltop_q == '0) ? LLast : ltop_q - 1'b1;
    if (accept) begin
      case (req)
        ReqAddNormal: begin
          log_rec   = 1'b1;
          l_wdata_o = ActAddNormal;
          if (ncount_q == NFull) begin
            sts_d = StsFull;
          end else begin
            sts_d    = StsAdded;
            n_we_o   = 1'b1;
            ntail_d  = (ntail_q == NLast) ? '0 : ntail_q + 1'b1;
            ncount_d = ncount_q + 1'b1;
          end
        end
        ReqAddPriority: begin
          log_rec   = 1'b1;
          l_wdata_o = ActAddPriority;
          if (pcount_q == PFull) begin
            sts_d = StsFull;
          end else begin
            sts_d    = StsAdded;
            p_we_o   = 1'b1;
            pcount_d = pcount_q + 1'b1;
          end
        end
        ReqProcess: begin
          log_rec   = 1'b1;
          l_wdata_o = ActProcess;
          if (pcount_q != '0) begin
            sts_d    = StsServedPrio;
            p_re_o   = 1'b1;
            pcount_d = pcount_q - 1'b1;
          end else if (ncount_q != '0) begin
            sts_d    = StsServedNorm;
            n_re_o   = 1'b1;
            nhead_d  = (nhead_q == NLast) ? '0 : nhead_q + 1'b1;
            ncount_d = ncount_q - 1'b1;
          end else begin
            sts_d = StsNothing;
          end
        end
        default: begin
          if (lcount_q == '0) begin
            sts_d = StsUndoEmpty;
          end else begin
            sts_d    = StsUndo;
            l_re_o   = 1'b1;
            ltop_d   = l_raddr_o;
            lcount_d = lcount_q - 1'b1;
          end
        end
      endcase
      if (log_rec) begin
        l_we_o = 1'b1;
        ltop_d = (ltop_q == LLast) ? '0 : ltop_q + 1'b1;
        if (lcount_q != LFull) begin
          lcount_d = lcount_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    mvalid_d  = mvalid_q;
    mstatus_d = mstatus_q;
    mserved_d = mserved_q;
    mundone_d = mundone_q;
    if (m_tready_i) begin
      mvalid_d = 1'b0;
    end
    if (load) begin
      mvalid_d  = 1'b1;
      mstatus_d = sts_q;
      mserved_d = '0;
      mundone_d = '0;
      case (sts_q)
        StsServedPrio: mserved_d = p_rdata_i;
        StsServedNorm: mserved_d = n_rdata_i;
        StsUndo:       mundone_d = l_rdata_i;
        default:       mserved_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      nhead_q  <= '0;
      ntail_q  <= '0;
      ncount_q <= '0;
      pcount_q <= '0;
      ltop_q   <= '0;
      lcount_q <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nhead_q  <= nhead_d;
      ntail_q  <= ntail_d;
      ncount_q <= ncount_d;
      pcount_q <= pcount_d;
      ltop_q   <= ltop_d;
      lcount_q <= lcount_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sts_q     <= sts_d;
    mstatus_q <= mstatus_d;
    mserved_q <= mserved_d;
    mundone_q <= mundone_d;
  end

  assign m_tvalid_o = mvalid_q;
  assign m_status_o = mstatus_q;
  assign m_served_o = mserved_q;
  assign m_undone_o = mundone_q;

`ifndef SYNTHESIS
  a_exec_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StExec))
    else $error("no execute cycle after input transfer");

  a_ring_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ncount_q == '0) || (ncount_q == NFull)) |-> (nhead_q == ntail_q))
    else $error("normal ring pointers disagree with count");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ncount_q <= NFull) && (pcount_q <= PFull) && (lcount_q <= LFull))
    else $error("store count beyond depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_tvalid_o && (m_status_o == $past(sts_q)))
    else $error("result not presented after execute");
`endif

endmodule

`default_nettype wire

@@ rtl/core/priority_lifo_over_fifo_task_queue.sv @@
// Result tvalid rises once the execute state that follows the input transfer
// has loaded the output register; execute is held while a held result is not taken.
// A new request is taken only in the idle state; the execute state waits for the
// registered read of the normal, priority or log memory.
// The output register holds a result while the next request is taken.
// Reset: asynchronous, clears counters, pointers and valid; stores stay uncleared.
`default_nettype none

module priority_lifo_over_fifo_task_queue
  import ptlq_pkg::*;
#(
  parameter int unsigned NormalDepth   = NormalDepthDef,
  parameter int unsigned PriorityDepth = PriorityDepthDef,
  parameter int unsigned LogDepth      = LogDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // task_id[15:0]
  input  wire logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o,  // served_id[15:0], undone_action[17:16]
  output logic      [2:0]  m_axis_tuser_o   // status[2:0]
);

  localparam int unsigned NIW = $clog2(NormalDepth);
  localparam int unsigned PIW = $clog2(PriorityDepth);
  localparam int unsigned LIW = $clog2(LogDepth);

  logic            n_we, n_re, p_we, p_re, l_we, l_re;
  logic [NIW-1:0]  n_waddr, n_raddr;
  logic [PIW-1:0]  p_waddr, p_raddr;
  logic [LIW-1:0]  l_waddr, l_raddr;
  logic [IdW-1:0]  n_rdata, p_rdata, served;
  logic [ActW-1:0] l_wdata, l_rdata, undone;

  ptlq_ctrl #(
    .NormalDepth  (NormalDepth),
    .PriorityDepth(PriorityDepth),
    .LogDepth     (LogDepth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .s_req_i   (s_axis_tuser_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_status_o(m_axis_tuser_o),
    .m_served_o(served),
    .m_undone_o(undone),
    .n_we_o    (n_we),
    .n_waddr_o (n_waddr),
    .n_re_o    (n_re),
    .n_raddr_o (n_raddr),
    .n_rdata_i (n_rdata),
    .p_we_o    (p_we),
    .p_waddr_o (p_waddr),
    .p_re_o    (p_re),
    .p_raddr_o (p_raddr),
    .p_rdata_i (p_rdata),
    .l_we_o    (l_we),
    .l_waddr_o (l_waddr),
    .l_wdata_o (l_wdata),
    .l_re_o    (l_re),
    .l_raddr_o (l_raddr),
    .l_rdata_i (l_rdata)
  );

  ptlq_ram #(.Width(IdW), .Depth(NormalDepth)) u_normal_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (n_re),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  ptlq_ram #(.Width(IdW), .Depth(PriorityDepth)) u_priority_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(s_axis_tdata_i),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  ptlq_ram #(.Width(ActW), .Depth(LogDepth)) u_log_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  assign m_axis_tdata_o = {6'd0, undone, served};

endmodule

`default_nettype wire
